// ===== rtl/sfr_pkg.sv =====
// Shared types and constants of the stuffed frame receiver.
`timescale 1ns / 1ps
`default_nettype none

package sfr_pkg;

	localparam int unsigned CRC_W = 16;

	localparam logic [7:0] START_BYTE     = 8'h7F;
	localparam logic [8:0] FRAME_OVERHEAD = 9'd5;
	localparam logic [8:0] BASE_LENGTH    = 9'd3;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_DEVICE_ADDRESS = 2'd0,
		REG_CRC_SEED       = 2'd1,
		REG_CRC_POLY       = 2'd2
	} sfr_reg_t;

	// One result as it waits in the output queue.
	typedef struct packed {
		logic [7:0] frame_byte;
		logic [8:0] byte_index;
		logic       restarted;
		logic       frame_end;
		logic       address_match;
		logic       frame_good;
		logic       sequence_bit;
	} sfr_result_t;

endpackage

`default_nettype wire

// ===== rtl/sfr_crc_byte.sv =====
// Byte-wide update of the MSB-first CRC-16, eight shift steps unrolled.
`timescale 1ns / 1ps
`default_nettype none

module sfr_crc_byte
	import sfr_pkg::*;
(
	input  wire logic [CRC_W-1:0] crc_in,
	input  wire logic [7:0]       data,
	input  wire logic [CRC_W-1:0] poly,
	output logic      [CRC_W-1:0] crc_out
);

	always_comb begin
		logic [CRC_W-1:0] acc;
		acc = crc_in ^ {data, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (acc[CRC_W-1]) begin
				acc = {acc[CRC_W-2:0], 1'b0} ^ poly;
			end else begin
				acc = {acc[CRC_W-2:0], 1'b0};
			end
		end
		crc_out = acc;
	end

endmodule

`default_nettype wire

// ===== rtl/stuffed_frame_receiver_crc16.sv =====
// Top level of the byte-stuffed frame receiver with CRC-16 check.
// Usage:
//   Serial bytes enter on the s_axis channel, one request per byte. Each byte is
//   unstuffed and placed into the current frame; bytes dropped while hunting
//   and a lone 0x7F or the first 0x7F of a doubled pair give no result. Every other byte gives
//   one result request on m_axis: the frame byte, its index, and flags. tlast
//   marks the last byte of a frame, where address_match and frame_good are valid.
//   Configuration writes on the cfg channel are always ready and must only be
//   issued while the receiver is idle.
//   A byte passes the input register, then one pass of framing and CRC logic
//   into the output queue, from which its result is offered.
//   Throughput: one byte per cycle while the queue has room (byte-wide CRC update).
//   When the downstream side stalls, the two-entry output queue fills and the
//   input register then holds its byte, so s_axis_tready falls; no result is
//   lost. s_axis_tready depends on registers only.
//   Reset clears the queue and returns the receiver to hunting for a start byte,
//   with device_address 0, crc_seed 0xFFFF and crc_poly 0x8005.
`timescale 1ns / 1ps
`default_nettype none

module stuffed_frame_receiver_crc16
	import sfr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Receive byte stream.
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	// Frame byte stream.
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata,   // [7:0] frame_byte, [16:8] byte_index, rest zero
	output logic [3:0]       m_axis_tuser,   // [0] restarted, [1] address_match,
	                                         // [2] frame_good, [3] sequence_bit
	output logic             m_axis_tlast,   // frame_end
	// Configuration writes.
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	localparam int unsigned QDEPTH = 2;

	// Configuration registers.
	logic [6:0]       dev_addr_q;
	logic [CRC_W-1:0] seed_q;
	logic [CRC_W-1:0] poly_q;

	// Input register.
	logic       valid_s1;
	logic [7:0] byte_s1;

	// Framing state.
	logic [8:0]       pos_q;
	logic             stuff_q;
	logic [8:0]       len_q;
	logic [CRC_W-1:0] crc_q;
	logic [7:0]       held_lo_q;
	logic [7:0]       addr_q;

	logic [8:0]       pos_n;
	logic             stuff_n;
	logic [8:0]       len_n;
	logic [CRC_W-1:0] crc_n;
	logic [7:0]       held_lo_n;
	logic [7:0]       addr_n;

	logic             has_result;
	sfr_result_t      res;
	logic             crc_from_seed;
	logic [CRC_W-1:0] crc_base;
	logic [CRC_W-1:0] crc_upd;

	// Output queue.
	sfr_result_t queue_q [QDEPTH];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;

	logic advance;
	logic push;
	logic pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q <= 7'd0;
			seed_q     <= 16'hFFFF;
			poly_q     <= 16'h8005;
		end else if (cfg_valid) begin
			unique case (sfr_reg_t'(cfg_index))
				REG_DEVICE_ADDRESS: dev_addr_q <= cfg_data[6:0];
				REG_CRC_SEED:       seed_q     <= cfg_data;
				REG_CRC_POLY:       poly_q     <= cfg_data;
				default:            ;
			endcase
		end
	end

	// The input register moves on whenever the queue has room for a result.
	assign advance       = valid_s1 && (count_q != 2'(QDEPTH));
	assign s_axis_tready = !valid_s1 || (count_q != 2'(QDEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	// The CRC restarts from the seed on the address byte, whether it follows the
	// start byte directly or comes after a lone start byte.
	assign crc_from_seed = (stuff_q && (byte_s1 != START_BYTE)) || (pos_q == 9'd1);
	assign crc_base      = crc_from_seed ? seed_q : crc_q;

	sfr_crc_byte u_crc (
		.crc_in  (crc_base),
		.data    (byte_s1),
		.poly    (poly_q),
		.crc_out (crc_upd)
	);

	always_comb begin
		logic       place;
		logic [9:0] p_ext;
		logic [9:0] len_ext;
		logic       match;

		pos_n      = pos_q;
		stuff_n    = stuff_q;
		len_n      = len_q;
		crc_n      = crc_q;
		held_lo_n  = held_lo_q;
		addr_n     = addr_q;
		has_result = 1'b0;
		res        = '0;
		place      = 1'b0;
		match      = 1'b0;
		p_ext      = {1'b0, pos_q};
		len_ext    = {1'b0, len_q};

		if (pos_q == 9'd0) begin
			// Hunting: only a start byte opens a frame.
			if (byte_s1 == START_BYTE) begin
				pos_n          = 9'd1;
				stuff_n        = 1'b0;
				len_n          = BASE_LENGTH;
				crc_n          = seed_q;
				addr_n         = 8'd0;
				has_result     = 1'b1;
				res.frame_byte = byte_s1;
			end
		end else begin
			if (stuff_q) begin
				stuff_n = 1'b0;
				if (byte_s1 != START_BYTE) begin
					// Lone start byte: this byte is the address of a new frame.
					addr_n           = byte_s1;
					crc_n            = crc_upd;
					len_n            = BASE_LENGTH;
					pos_n            = 9'd2;
					has_result       = 1'b1;
					res.frame_byte   = byte_s1;
					res.byte_index   = 9'd1;
					res.restarted    = 1'b1;
					res.sequence_bit = byte_s1[7];
				end else begin
					place = 1'b1;
				end
			end else if (byte_s1 == START_BYTE) begin
				stuff_n = 1'b1;
			end else begin
				place = 1'b1;
			end

			if (place) begin
				pos_n = pos_q + 9'd1;
				if (pos_q == 9'd1) begin
					addr_n = byte_s1;
					crc_n  = crc_upd;
				end else if (pos_q == 9'd2) begin
					len_n = {1'b0, byte_s1} + FRAME_OVERHEAD;
					crc_n = crc_upd;
				end else if (p_ext + 10'd2 == len_ext) begin
					held_lo_n = byte_s1;
				end else if (p_ext + 10'd1 == len_ext) begin
					// The CRC high byte is compared straight from the input.
				end else begin
					crc_n = crc_upd;
				end

				has_result       = 1'b1;
				res.frame_byte   = byte_s1;
				res.byte_index   = pos_q;
				res.sequence_bit = addr_n[7];

				if (pos_n == len_n) begin
					match             = (addr_n[6:0] == dev_addr_q);
					res.frame_end     = 1'b1;
					res.address_match = match;
					res.frame_good    = match && (held_lo_n == crc_n[7:0])
					                    && (byte_s1 == crc_n[15:8]);
					pos_n             = 9'd0;
					stuff_n           = 1'b0;
					len_n             = BASE_LENGTH;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= 9'd0;
			stuff_q   <= 1'b0;
			len_q     <= BASE_LENGTH;
			crc_q     <= 16'hFFFF;
			held_lo_q <= 8'd0;
			addr_q    <= 8'd0;
		end else if (advance) begin
			pos_q     <= pos_n;
			stuff_q   <= stuff_n;
			len_q     <= len_n;
			crc_q     <= crc_n;
			held_lo_q <= held_lo_n;
			addr_q    <= addr_n;
		end
	end

	// Two-entry output queue decouples the stream sides.
	assign push = advance && has_result;
	assign pop  = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= res;
		end
	end

	always_comb begin
		sfr_result_t head;
		head            = queue_q[rd_ptr_q];
		m_axis_tvalid   = (count_q != 2'd0);
		m_axis_tdata    = {7'd0, head.byte_index, head.frame_byte};
		m_axis_tuser    = {head.sequence_bit, head.frame_good, head.address_match,
		                   head.restarted};
		m_axis_tlast    = head.frame_end;
	end

	// A good frame always matched the address and ends the frame.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[2]) |-> (m_axis_tuser[1] && m_axis_tlast))
		else $error("frame_good reported without address match or frame end");

	// A restart result is always the address position and never ends a frame.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[0]) |->
		(m_axis_tdata[16:8] == 9'd1 && !m_axis_tlast))
		else $error("restart result with wrong index or frame end");

	// Index zero is only ever given to the start byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[16:8] == 9'd0) |->
		(m_axis_tdata[7:0] == START_BYTE && m_axis_tuser == 4'd0))
		else $error("index zero on a byte other than the start byte");

	// After a frame end the receiver is back to hunting.
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && res.frame_end) |=> (pos_q == 9'd0 && !stuff_q))
		else $error("receiver not hunting after frame end");

endmodule

`default_nettype wire

// ===== tb/stuffed_frame_receiver_crc16_tb.sv =====
// Self-checking testbench of the byte-stuffed frame receiver with CRC-16 check.
`timescale 1ns / 1ps

module stuffed_frame_receiver_crc16_tb;

	import sfr_pkg::*;

	// Clock, reset and the ports of the receiver. Every input starts at a known value.
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;     // [7:0] rx_byte
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;             // [7:0] frame_byte, [16:8] byte_index
	logic [3:0]  m_axis_tuser;             // [0] restarted, [1] address_match,
	                                       // [2] frame_good, [3] sequence_bit
	logic        m_axis_tlast;             // frame_end
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = 2'd0;
	logic [15:0] cfg_data = 16'h0000;

	stuffed_frame_receiver_crc16 dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// A 12 ns clock, high and low for half a period each.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Shadow copy of the configuration registers, as they stand after reset.
	logic [6:0]  addr_cfg = 7'h00;
	logic [15:0] seed_cfg = 16'hFFFF;
	logic [15:0] poly_cfg = 16'h8005;

	// Our own copy of the framing state, updated once per accepted byte.
	logic [8:0]  rx_pos = 9'd0;
	logic        pair_open = 1'b0;
	logic [8:0]  frame_len = BASE_LENGTH;
	logic [15:0] crc_run = 16'hFFFF;
	logic [7:0]  crc_lo_rx = 8'h00;
	logic [7:0]  crc_hi_rx = 8'h00;
	logic [7:0]  addr_byte = 8'h00;

	// Serial bytes still to be offered, and the results that the receiver owes us.
	logic [7:0]  line_bytes[$];
	sfr_result_t frame_results[$];
	logic [7:0]  payload_buf[$];

	sfr_result_t seen, want, predicted;
	logic        rx_taken = 1'b0;
	int unsigned bytes_queued = 0;
	int unsigned bytes_accepted = 0;
	int unsigned mismatches = 0;
	int unsigned long_frames = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;

	// One byte through the MSB-first CRC register, eight shifts against the polynomial.
	function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = (c << 1) ^ poly_cfg;
			end else begin
				c = c << 1;
			end
		end
		return c;
	endfunction

	// Advances the framing state by one received byte. Returns 1 when the byte gives a
	// result, which is then left in res.
	function automatic bit unstuff_byte(input logic [7:0] rx, output sfr_result_t res);
		logic [8:0] p;
		logic       match;
		res = '0;
		res.frame_byte = rx;

		// While hunting, only a start byte opens a frame; its address is not known yet.
		if (rx_pos == 9'd0) begin
			if (rx != START_BYTE) begin
				return 1'b0;
			end
			rx_pos = 9'd1;
			pair_open = 1'b0;
			frame_len = BASE_LENGTH;
			crc_run = seed_cfg;
			addr_byte = 8'h00;
			return 1'b1;
		end

		// A lone 0x7F followed by anything else starts the frame again at the address.
		if (pair_open) begin
			pair_open = 1'b0;
			if (rx != START_BYTE) begin
				addr_byte = rx;
				crc_run = crc16_step(seed_cfg, rx);
				frame_len = BASE_LENGTH;
				rx_pos = 9'd2;
				res.byte_index = 9'd1;
				res.restarted = 1'b1;
				res.sequence_bit = rx[7];
				return 1'b1;
			end
		end else if (rx == START_BYTE) begin
			pair_open = 1'b1;
			return 1'b0;
		end

		p = rx_pos;
		rx_pos = p + 9'd1;
		if (p == 9'd1) begin
			addr_byte = rx;
			crc_run = crc16_step(seed_cfg, rx);
		end else if (p == 9'd2) begin
			// The length byte counts the data only; the frame adds start, address,
			// length and two check bytes.
			frame_len = {1'b0, rx} + FRAME_OVERHEAD;
			crc_run = crc16_step(crc_run, rx);
		end else if (p + 9'd2 == frame_len) begin
			crc_lo_rx = rx;
		end else if (p + 9'd1 == frame_len) begin
			crc_hi_rx = rx;
		end else begin
			crc_run = crc16_step(crc_run, rx);
		end

		res.byte_index = p;
		res.sequence_bit = addr_byte[7];
		if (rx_pos == frame_len) begin
			match = (addr_byte[6:0] == addr_cfg);
			res.frame_end = 1'b1;
			res.address_match = match;
			res.frame_good = match && crc_lo_rx == crc_run[7:0] && crc_hi_rx == crc_run[15:8];
			rx_pos = 9'd0;
			pair_open = 1'b0;
			frame_len = BASE_LENGTH;
		end
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("%0t: %s", $time, what);
	endtask

	task automatic check_field(input string name, input int unsigned got,
			input int unsigned exp_val);
		if (got != exp_val) begin
			report_mismatch($sformatf("%s is %0h, expected %0h (frame byte %02h, index %0d)",
				name, got, exp_val, want.frame_byte, want.byte_index));
		end
	endtask

	// Driver: presents the next serial byte at the falling edge once the previous
	// request has been taken, and also decides whether the result side stalls.
	always @(negedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			m_axis_tready <= 1'b0;
		end else begin
			if (!s_axis_tvalid || rx_taken) begin
				if (line_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= line_bytes.pop_front();
				end else begin
					s_axis_tvalid <= 1'b0;
					s_axis_tdata <= 8'($urandom);
				end
			end
			m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Monitor: checks each result request against the oldest prediction, then feeds
	// each accepted serial byte through the predictor.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			seen.frame_byte    = m_axis_tdata[7:0];
			seen.byte_index    = m_axis_tdata[16:8];
			seen.restarted     = m_axis_tuser[0];
			seen.frame_end     = m_axis_tlast;
			seen.address_match = m_axis_tuser[1];
			seen.frame_good    = m_axis_tuser[2];
			seen.sequence_bit  = m_axis_tuser[3];
			if (frame_results.size() == 0) begin
				report_mismatch($sformatf("result with nothing pending: byte %02h index %0d",
					seen.frame_byte, seen.byte_index));
			end else begin
				want = frame_results.pop_front();
				check_field("frame_byte", seen.frame_byte, want.frame_byte);
				check_field("byte_index", seen.byte_index, want.byte_index);
				check_field("restarted", seen.restarted, want.restarted);
				check_field("frame_end", seen.frame_end, want.frame_end);
				check_field("address_match", seen.address_match, want.address_match);
				check_field("frame_good", seen.frame_good, want.frame_good);
				check_field("sequence_bit", seen.sequence_bit, want.sequence_bit);
			end
		end
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			bytes_accepted++;
			if (unstuff_byte(s_axis_tdata, predicted)) begin
				frame_results.push_back(predicted);
			end
		end
		rx_taken <= arst_n && s_axis_tvalid && s_axis_tready;
	end

	task automatic push_raw(input logic [7:0] b);
		line_bytes.push_back(b);
		bytes_queued++;
	endtask

	// Queues one frame on the line: start byte, address, length, payload and the check
	// bytes low first, with every 0x7F after the start doubled. A non-zero cut keeps
	// only that many unstuffed bytes after the start, leaving the frame broken off.
	task automatic queue_frame(input logic [7:0] addr, input logic [7:0] payload[$],
			input bit crc_ok, input int unsigned cut);
		logic [7:0]  body[$];
		logic [15:0] crc;
		int unsigned keep;
		body.push_back(addr);
		crc = crc16_step(seed_cfg, addr);
		body.push_back(8'(payload.size()));
		crc = crc16_step(crc, 8'(payload.size()));
		foreach (payload[i]) begin
			body.push_back(payload[i]);
			crc = crc16_step(crc, payload[i]);
		end
		if (!crc_ok) begin
			crc ^= 16'h0001 << $urandom_range(0, 15);
		end
		body.push_back(crc[7:0]);
		body.push_back(crc[15:8]);
		keep = (cut != 0 && cut < body.size()) ? cut : body.size();
		push_raw(START_BYTE);
		for (int i = 0; i < keep; i++) begin
			push_raw(body[i]);
			if (body[i] == START_BYTE) begin
				push_raw(body[i]);
			end
		end
	endtask

	// Mostly well-formed frames with random content; the rest is line noise, frames
	// broken off part way (so that the next start byte restarts them) and bad checks.
	// At most two frames of full length or of length 0x7F appear in the whole run, a full-length one only as the first.
	task automatic queue_random_traffic(input int unsigned target);
		int unsigned first, r, r2, body_len, cut;
		logic [7:0]  addr;
		bit          broken_prev;
		first = bytes_queued;
		broken_prev = 1'b0;
		while (bytes_queued - first < target) begin
			r = $urandom_range(0, 99);
			if (r < 8) begin
				repeat ($urandom_range(1, 4)) push_raw(8'($urandom));
				// Noise always closes on a byte other than 0x7F.
				push_raw(8'($urandom_range(0, 8'h7E)));
				broken_prev = 1'b1;
			end else begin
				r2 = $urandom_range(0, 99);
				if (r2 < 2 && long_frames < 1) begin
					body_len = 255;
					long_frames++;
				end else if (r2 < 5 && long_frames < 2) begin
					// A length of 0x7F goes out stuffed.
					body_len = 127;
					long_frames++;
				end else if (r2 < 20) begin
					body_len = $urandom_range(7, 40);
				end else begin
					body_len = $urandom_range(0, 6);
				end
				payload_buf = {};
				repeat (body_len) begin
					payload_buf.push_back(($urandom_range(0, 99) < 15) ? START_BYTE
						: 8'($urandom));
				end
				if ($urandom_range(0, 99) < 60) begin
					addr = {1'($urandom), addr_cfg};
				end else begin
					addr = 8'($urandom);
				end
				// After a broken frame the start byte must be followed by something other
				// than 0x7F to act as a restart.
				if (broken_prev && addr == START_BYTE) begin
					addr = 8'hFF;
				end
				cut = (r < 20) ? $urandom_range(1, body_len + 3) : 0;
				queue_frame(addr, payload_buf, $urandom_range(0, 99) < 80, cut);
				broken_prev = (cut != 0);
			end
		end
	endtask

	// Waits until every queued byte has been taken and every result has arrived, then
	// waits on for a last byte that gives no result to pass through the receiver.
	task automatic wait_idle();
		do @(negedge clk); while (bytes_accepted != bytes_queued || frame_results.size() != 0);
		repeat (6) @(negedge clk);
	endtask

	task automatic write_reg(input sfr_reg_t idx, input logic [15:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_DEVICE_ADDRESS: addr_cfg = val[6:0];
			REG_CRC_SEED:       seed_cfg = val;
			REG_CRC_POLY:       poly_cfg = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_traffic_phase(input logic [6:0] dev_addr, input logic [15:0] seed,
			input logic [15:0] poly, input int unsigned idle, input int unsigned stall);
		write_reg(REG_DEVICE_ADDRESS, {9'd0, dev_addr});
		write_reg(REG_CRC_SEED, seed);
		write_reg(REG_CRC_POLY, poly);
		@(posedge clk);
		send_idle_pct = idle;
		recv_stall_pct = stall;
		queue_random_traffic(100);
		wait_idle();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening with the registers at their reset values and no idling.
		// Bytes other than 0x7F are dropped while hunting.
		push_raw(8'h00);
		push_raw(8'hFF);
		// A matching frame whose data holds a doubled 0x7F and an all-ones byte.
		payload_buf = {START_BYTE, 8'hFF};
		queue_frame(8'h00, payload_buf, 1'b1, 0);
		// A frame broken off after its address, restarted by a lone start byte; the
		// restarted frame carries a sequence bit and a bad check.
		payload_buf = {};
		queue_frame(8'h85, payload_buf, 1'b1, 1);
		queue_frame(8'h80, payload_buf, 1'b0, 0);
		// Address 0x7F goes out stuffed and does not match address zero.
		queue_frame(START_BYTE, payload_buf, 1'b1, 0);
		wait_idle();

		// Random phases, each with its own register settings and idling pattern.
		run_traffic_phase(7'h7F, 16'h0000, 16'h1021, 0, 0);
		run_traffic_phase(7'h00, 16'hFFFF, 16'hFFFF, 47, 0);
		run_traffic_phase(7'($urandom), 16'($urandom), 16'($urandom), 0, 47);
		run_traffic_phase(7'h55, 16'h1D0F, 16'h0000, 10, 10);
		run_traffic_phase(7'($urandom), 16'($urandom), 16'h8005, 0, 0);

		if (frame_results.size() != 0) begin
			report_mismatch($sformatf("%0d results never arrived", frame_results.size()));
		end
		if (mismatches == 0) begin
			$display("stuffed_frame_receiver_crc16_tb: done, clean");
		end else begin
			$display("stuffed_frame_receiver_crc16_tb: done, errors");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#2000000;
		$display("stuffed_frame_receiver_crc16_tb: done, errors");
		$finish;
	end

endmodule
